@@ rtl/lfu_cache_policy_defines.svh @@
// ----------------------------------------------------------------------------
// LFU cache policy assertion macros
// Shared concurrent assertion forms used by the cache policy RTL.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_POLICY_DEFINES_SVH
`define LFU_CACHE_POLICY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LFU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LFU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// LFU cache policy package
// Request/response word types and fixed constants of the cache policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

   // fixed field widths
   localparam int KEY_W   = 32;
   localparam int TOUCH_W = 64;
   localparam int CAP_W   = 7;

   // capacity register after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // request codes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // request word
   typedef struct packed {
      logic              req_type;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_word_type;

   // response word
   typedef struct packed {
      logic              hit;
      logic signed [31:0] read_value;
      logic              evicted;
      logic signed [31:0] evicted_key;
   } rsp_word_type;

endpackage

`default_nettype wire

@@ rtl/lfu_cache_policy.sv @@
// Requests are taken one at a time: busy stays high from the accepting edge until the
//   result strobe rises, so no new request is taken before the last one is through.
// The entry RAM read port is walked one entry per cycle, then the update state
//   (ST_APPLY) applies the request and registers the result.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active high) clears valid bits, occupancy, touch stamp and
//   sets capacity to 64; entry RAM contents are left as they are.
// ----------------------------------------------------------------------------
// LFU cache policy
// Fully associative key/value store, least-frequently-used replacement with a
// least-recently-touched tie break. One entry scanned per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lfu_cache_policy_defines.svh"

module lfu_cache_policy
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_word_type     req_data,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CAP_W-1:0] csr_wr_data
);

   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
   localparam int ENTRY_W = KEY_W + KEY_W + COUNT_BITS + TOUCH_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   state_type              state_ff, state_in;
   req_word_type           req_ff, req_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic                   issue_ff, issue_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   match_ff, match_in;
   logic [IDX_W-1:0]       match_idx_ff, match_idx_in;
   logic [KEY_W-1:0]       match_value_ff, match_value_in;
   logic [COUNT_BITS-1:0]  match_count_ff, match_count_in;
   logic                   have_ff, have_in;
   logic [IDX_W-1:0]       victim_idx_ff, victim_idx_in;
   logic [COUNT_BITS-1:0]  victim_count_ff, victim_count_in;
   logic [TOUCH_W-1:0]     victim_touch_ff, victim_touch_in;
   logic [KEY_W-1:0]       victim_key_ff, victim_key_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [TOUCH_W-1:0]     stamp_ff, stamp_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_ff, rsp_in;

   // entry RAM ports
   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [ENTRY_W-1:0]     ram_wr_data;
   logic [ENTRY_W-1:0]     ram_rd_data;

   // fields of the word coming out of the RAM
   logic [KEY_W-1:0]       rd_key;
   logic [KEY_W-1:0]       rd_value;
   logic [COUNT_BITS-1:0]  rd_count;
   logic [TOUCH_W-1:0]     rd_touch;
   logic                   rd_entry_valid;
   logic                   rd_better;

   // update decisions
   logic [CMP_W-1:0]       cap_wide;
   logic [CMP_W-1:0]       cap_eff;
   logic                   is_put;
   logic                   need_evict;
   logic                   do_insert;
   logic [IDX_W-1:0]       ins_idx;
   logic [COUNT_BITS-1:0]  bumped_count;

   lfu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue_ff),
      .rd_addr (scan_ff),
      .rd_data (ram_rd_data)
   );

   // split the entry word
   assign rd_key   = ram_rd_data[ENTRY_W-1 -: KEY_W];
   assign rd_value = ram_rd_data[ENTRY_W-KEY_W-1 -: KEY_W];
   assign rd_count = ram_rd_data[TOUCH_W +: COUNT_BITS];
   assign rd_touch = ram_rd_data[TOUCH_W-1:0];
   assign rd_entry_valid = valid_ff[rd_idx_ff];

   // victim compare unit: lower count wins, older touch breaks the tie
   assign rd_better = {rd_count, rd_touch} < {victim_count_ff, victim_touch_ff};

   // effective capacity, clamped to the store depth
   assign cap_wide = CMP_W'(cap_ff);
   assign cap_eff  = (cap_wide > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_wide;

   assign is_put     = (req_ff.req_type == REQ_PUT);
   assign need_evict = is_put && !match_ff && (cap_eff != '0) && have_ff &&
                       (CMP_W'(occ_ff) >= cap_eff);
   assign do_insert  = is_put && !match_ff && (cap_eff != '0) && (need_evict || free_ff);
   assign ins_idx    = (need_evict && !(free_ff && (free_idx_ff < victim_idx_ff))) ?
                       victim_idx_ff : free_idx_ff;
   assign bumped_count = (match_count_ff == '1) ? match_count_ff :
                         COUNT_BITS'(match_count_ff + 1'b1);

   // next-state and datapath
   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      scan_in         = scan_ff;
      issue_in        = 1'b0;
      rd_vld_in       = 1'b0;
      rd_idx_in       = scan_ff;
      match_in        = match_ff;
      match_idx_in    = match_idx_ff;
      match_value_in  = match_value_ff;
      match_count_in  = match_count_ff;
      have_in         = have_ff;
      victim_idx_in   = victim_idx_ff;
      victim_count_in = victim_count_ff;
      victim_touch_in = victim_touch_ff;
      victim_key_in   = victim_key_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      valid_in        = valid_ff;
      occ_in          = occ_ff;
      stamp_in        = stamp_ff;
      cap_in          = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = match_idx_ff;
      ram_wr_data     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               scan_in  = '0;
               issue_in = 1'b1;
               match_in = 1'b0;
               have_in  = 1'b0;
               free_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // address side: one entry read per cycle
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               if (scan_ff != LAST_IDX) begin
                  scan_in  = scan_ff + 1'b1;
                  issue_in = 1'b1;
               end
            end
            // data side: key match, victim and first free slot
            if (rd_vld_ff) begin
               if (rd_entry_valid && (rd_key == req_ff.key) && !match_ff) begin
                  match_in       = 1'b1;
                  match_idx_in   = rd_idx_ff;
                  match_value_in = rd_value;
                  match_count_in = rd_count;
               end
               if (!rd_entry_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_entry_valid && (!have_ff || rd_better)) begin
                  have_in         = 1'b1;
                  victim_idx_in   = rd_idx_ff;
                  victim_count_in = rd_count;
                  victim_touch_in = rd_touch;
                  victim_key_in   = rd_key;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_APPLY;
               end
            end
         end

         ST_APPLY: begin
            // hit: refresh the matched entry
            if (match_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = match_idx_ff;
               ram_wr_data = {req_ff.key, (is_put ? req_ff.value : match_value_ff),
                              bumped_count, stamp_ff};
               stamp_in    = stamp_ff + 1'b1;
            end
            // put miss: evict when at capacity, then insert
            if (need_evict) begin
               valid_in[victim_idx_ff] = 1'b0;
            end
            if (do_insert) begin
               ram_wr_en         = 1'b1;
               ram_wr_addr       = ins_idx;
               ram_wr_data       = {req_ff.key, req_ff.value, COUNT_BITS'(1), stamp_ff};
               valid_in[ins_idx] = 1'b1;
               stamp_in          = stamp_ff + 1'b1;
               if (!need_evict) begin
                  occ_in = occ_ff + 1'b1;
               end
            end else if (need_evict) begin
               occ_in = occ_ff - 1'b1;
            end
            rsp_valid_in       = 1'b1;
            rsp_in.hit         = match_ff;
            rsp_in.read_value  = (match_ff && !is_put) ? match_value_ff : '0;
            rsp_in.evicted     = need_evict;
            rsp_in.evicted_key = need_evict ? victim_key_ff : '0;
            state_in           = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         stamp_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         stamp_ff     <= stamp_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff          <= req_in;
      scan_ff         <= scan_in;
      rd_idx_ff       <= rd_idx_in;
      match_ff        <= match_in;
      match_idx_ff    <= match_idx_in;
      match_value_ff  <= match_value_in;
      match_count_ff  <= match_count_in;
      have_ff         <= have_in;
      victim_idx_ff   <= victim_idx_in;
      victim_count_ff <= victim_count_in;
      victim_touch_ff <= victim_touch_in;
      victim_key_ff   <= victim_key_in;
      free_ff         <= free_in;
      free_idx_ff     <= free_idx_in;
      rsp_ff          <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `LFU_ASSERT_IMP(a_rsp_after_apply, clock, reset, rsp_valid, $past(state_ff == ST_APPLY), "result without update cycle")
   `LFU_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "accepted word did not raise busy")
   `LFU_ASSERT_NXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `LFU_ASSERT_IMP(a_evict_only_miss, clock, reset, rsp_valid && rsp_data.evicted, !rsp_data.hit, "eviction on a hit")
   `LFU_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(MAX_ENTRIES), "occupancy above depth")

endmodule

`default_nettype wire

@@ rtl/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// LFU generic RAM
// Single write port, single read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ bench/lfu_cache_policy_checker.sv @@
// ----------------------------------------------------------------------------
// LFU cache policy checker
// Watches the request, result and capacity ports of the cache policy block,
// keeps its own copy of the entry table, predicts one result word per
// accepted request and compares each strobed result against the oldest
// prediction. Mismatch count and outstanding results go back to the top.
// ----------------------------------------------------------------------------
module lfu_cache_policy_checker
   import lfu_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int COUNT_BITS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_word_type     req_data,
   input  logic             rsp_valid,
   input  rsp_word_type     rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   output int               mismatches,
   output int               rsp_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // predicted entry table
   logic                  line_valid [MAX_ENTRIES];
   logic [KEY_W-1:0]      line_key   [MAX_ENTRIES];
   logic [31:0]           line_value [MAX_ENTRIES];
   logic [COUNT_BITS-1:0] line_uses  [MAX_ENTRIES];
   logic [TOUCH_W-1:0]    line_touch [MAX_ENTRIES];
   logic [TOUCH_W-1:0]    touch_stamp;
   int                    occupancy;
   logic [CAP_W-1:0]      capacity;

   // result words owed by the block, oldest first
   rsp_word_type          due_rsp_q [$];

   initial begin
      mismatches = 0;
      rsp_owed   = 0;
   end

   task automatic flag_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   function automatic void clear_table();
      int i;
      for (i = 0; i < MAX_ENTRIES; i++) line_valid[i] = 1'b0;
      touch_stamp = '0;
      occupancy   = 0;
      capacity    = CAP_RESET;
   endfunction

   // count saturates, recency always refreshed
   function automatic void bump_line(input int idx);
      if (line_uses[idx] != '1) line_uses[idx]++;
      line_touch[idx] = touch_stamp;
      touch_stamp++;
   endfunction

   // apply one request to the table and return the word it should produce
   function automatic rsp_word_type serve_request(input req_word_type r);
      rsp_word_type res;
      int           cap;
      int           slot;
      int           victim;
      int           i;
      res  = '0;
      cap  = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
      slot = -1;
      for (i = 0; i < MAX_ENTRIES; i++) begin
         if (slot < 0 && line_valid[i] && line_key[i] == r.key) slot = i;
      end

      // hit: read or overwrite, then bump
      if (slot >= 0) begin
         res.hit = 1'b1;
         if (r.req_type == REQ_GET) res.read_value = line_value[slot];
         else line_value[slot] = r.value;
         bump_line(slot);
         return res;
      end

      // get miss and put with zero capacity change nothing
      if (r.req_type == REQ_GET || cap == 0) return res;

      // full (or over capacity): drop lowest count, oldest touch on a tie
      if (occupancy >= cap) begin
         victim = -1;
         for (i = 0; i < MAX_ENTRIES; i++) begin
            if (line_valid[i]) begin
               if (victim < 0 || line_uses[i] < line_uses[victim] ||
                   (line_uses[i] == line_uses[victim] &&
                    line_touch[i] < line_touch[victim])) victim = i;
            end
         end
         if (victim >= 0) begin
            line_valid[victim] = 1'b0;
            if (occupancy > 0) occupancy--;
            res.evicted     = 1'b1;
            res.evicted_key = line_key[victim];
         end
      end

      // insert into the first free line
      for (i = 0; i < MAX_ENTRIES; i++) begin
         if (!line_valid[i]) begin
            line_valid[i] = 1'b1;
            line_key[i]   = r.key;
            line_value[i] = r.value;
            line_uses[i]  = COUNT_BITS'(1);
            line_touch[i] = touch_stamp;
            touch_stamp++;
            occupancy++;
            break;
         end
      end
      return res;
   endfunction

   // sample at the rising edge; results first, they belong to older words
   always @(posedge clock) begin : watch_ports
      rsp_word_type want;
      if (reset) begin
         clear_table();
         due_rsp_q.delete();
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (rsp_valid) begin
            if (due_rsp_q.size() == 0) begin
               flag_mismatch($sformatf("result word with nothing outstanding: %h",
                                       rsp_data));
            end else begin
               want = due_rsp_q.pop_front();
               if (rsp_data.hit !== want.hit)
                  flag_mismatch($sformatf("hit got %b want %b",
                                          rsp_data.hit, want.hit));
               if (rsp_data.read_value !== want.read_value)
                  flag_mismatch($sformatf("read_value got %h want %h",
                                          rsp_data.read_value, want.read_value));
               if (rsp_data.evicted !== want.evicted)
                  flag_mismatch($sformatf("evicted got %b want %b",
                                          rsp_data.evicted, want.evicted));
               if (rsp_data.evicted_key !== want.evicted_key)
                  flag_mismatch($sformatf("evicted_key got %h want %h",
                                          rsp_data.evicted_key, want.evicted_key));
            end
         end
         if (start && !busy) due_rsp_q.push_back(serve_request(req_data));
      end
      rsp_owed = due_rsp_q.size();
   end

endmodule

@@ bench/tb_lfu_cache_policy.sv @@
// ----------------------------------------------------------------------------
// LFU cache policy testbench
// Drives directed requests covering hits, misses, tie-broken evictions, count
// saturation, zero capacity and capacity dropped below the current fill, then
// random get/put traffic over a skewed key pool across a sequence of capacity
// settings, oversized ones included, with random sender idling. Checking is
// done by the checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_lfu_cache_policy;
   timeunit 1ns;
   timeprecision 1ps;
   import lfu_pkg::*;

   localparam int MAX_ENTRIES = 64;
   // narrow counters so saturation is reachable in a short run
   localparam int COUNT_BITS  = 4;
   localparam int N_PHASES    = 10;
   localparam int PHASE_ITEMS = 168;
   localparam int POOL_SIZE   = 128;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_word_type     req_data = '0;
   logic             rsp_valid;
   rsp_word_type     rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   int               mismatches;
   int               rsp_owed;

   logic [31:0]      key_pool [POOL_SIZE];

   always #10 clock = ~clock;

   lfu_cache_policy #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_BITS  (COUNT_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lfu_cache_policy_checker #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_BITS  (COUNT_BITS)
   ) policy_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .rsp_owed    (rsp_owed)
   );

   function automatic req_word_type make_word(input logic kind, input logic [31:0] k,
                                              input logic [31:0] v);
      req_word_type w;
      w.req_type = kind;
      w.key      = k;
      w.value    = v;
      return w;
   endfunction

   // mostly pooled keys, a hot subset for repeat hits, some stray keys
   function automatic req_word_type pick_word(input int pool_n);
      logic [31:0] k;
      int          roll;
      roll = $urandom_range(99);
      if (roll < 10) k = $urandom;
      else if (roll < 40) k = key_pool[$urandom_range(pool_n / 8)];
      else k = key_pool[$urandom_range(pool_n - 1)];
      return make_word($urandom_range(1) ? REQ_PUT : REQ_GET, k, $urandom);
   endfunction

   // present a word at the falling edge and hold it until accepted
   task automatic send_word(input req_word_type w);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
   endtask

   // drop start for a burst, optionally counted from the end of busy
   task automatic idle_sender(input int n, input bit past_busy);
      @(negedge clock);
      start <= 1'b0;
      if (past_busy) while (busy) @(negedge clock);
      repeat (n - 1) @(negedge clock);
   endtask

   // hold off until every outstanding result has been seen
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (rsp_owed != 0 || busy) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // run time limit
   initial begin
      #20ms;
      $display("lfu_cache_policy: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic [CAP_W-1:0] caps [N_PHASES];
      int               pool_n;
      int               eff;
      bit               quiet;
      int               i;
      int               p;
      int               n;

      caps = '{7'd1, 7'd2, 7'd5, 7'd64, 7'd0, 7'd100, 7'd127, 7'd3, 7'd40, 7'd64};
      for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // basic get/put with extreme keys and values at reset capacity
      send_word(make_word(REQ_GET, 32'h0000_0000, 32'h0000_0000));
      send_word(make_word(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
      send_word(make_word(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
      send_word(make_word(REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
      send_word(make_word(REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF));
      send_word(make_word(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000));

      // equal counts: the older touch goes first
      write_capacity(7'd2);
      send_word(make_word(REQ_PUT, 32'd5, 32'h1234_5678));
      // drive key 5 past the top of its counter
      repeat ((1 << COUNT_BITS) - 1) send_word(make_word(REQ_GET, 32'd5, 32'd0));
      send_word(make_word(REQ_PUT, 32'd9, 32'h0BAD_F00D));

      // zero capacity: put miss is ignored, hits still served
      write_capacity(7'd0);
      send_word(make_word(REQ_PUT, 32'd77, 32'd1));
      send_word(make_word(REQ_GET, 32'd5, 32'd0));

      // capacity below fill: one eviction per insert
      write_capacity(7'd1);
      send_word(make_word(REQ_PUT, 32'd11, 32'd2));

      // random traffic over a series of capacities, no idling in the last one
      for (p = 0; p < N_PHASES; p++) begin
         write_capacity(caps[p]);
         eff    = (caps[p] > MAX_ENTRIES) ? MAX_ENTRIES : int'(caps[p]);
         pool_n = (eff < 1 ? 1 : eff) + eff / 2 + 4;
         if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
         quiet = 1'b0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 32 == 0) quiet = ($urandom_range(3) == 0) || (p == N_PHASES - 1);
            send_word(pick_word(pool_n));
            if (!quiet && $urandom_range(2) == 0)
               idle_sender($urandom_range(6, 1), 1'($urandom_range(1)));
         end
      end

      drain_results();
      repeat (MAX_ENTRIES + 8) @(negedge clock);
      if (mismatches == 0 && rsp_owed == 0) begin
         $display("lfu_cache_policy: match");
      end else begin
         $display("lfu_cache_policy: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cache_policy.sv
bench/lfu_cache_policy_checker.sv
bench/tb_lfu_cache_policy.sv
